FILE: hw/rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types, constants and tables for the occupancy-grid ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int GridSide      = 128;
  localparam int CoordW        = 7;
  localparam int AddrW         = 2 * CoordW;
  localparam int QueueDepth    = 2;

  localparam logic [1:0] CellFree     = 2'd0;
  localparam logic [1:0] CellOccupied = 2'd1;
  localparam logic [1:0] CellUnknown  = 2'd2;

  localparam logic OpWrite = 1'b0;
  localparam logic OpCast  = 1'b1;

  localparam logic [0:0] RegMapRows = 1'd0;
  localparam logic [0:0] RegMapCols = 1'd1;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic                   is_cast;
    logic [CoordW-1:0]      x;
    logic [CoordW-1:0]      y;
    logic [1:0]             code;
    logic [3:0]             direction;
  } grc_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_WALK,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } grc_state_t;

  // Per-direction walk setup: major axis, step sign, and the change of the
  // minor coordinate per major step (Q1.12, signed, step sign included).
  typedef struct packed {
    logic              xmajor;
    logic              step_neg;
    logic signed [13:0] slope;
  } grc_dir_t;

  // Direction k points at 22*k degrees.
  function automatic grc_dir_t dir_info(input logic [3:0] k);
    grc_dir_t d;
    d = '0;
    case (k)
      4'd0:  d = '{1'b1, 1'b0, 14'sd0};
      4'd1:  d = '{1'b1, 1'b0, 14'sd1655};
      4'd2:  d = '{1'b1, 1'b0, 14'sd3955};
      4'd3:  d = '{1'b0, 1'b0, 14'sd1824};
      4'd4:  d = '{1'b0, 1'b0, 14'sd143};
      4'd5:  d = '{1'b0, 1'b0, -14'sd1491};
      4'd6:  d = '{1'b0, 1'b0, -14'sd3688};
      4'd7:  d = '{1'b1, 1'b1, 14'sd1998};
      4'd8:  d = '{1'b1, 1'b1, 14'sd286};
      4'd9:  d = '{1'b1, 1'b1, -14'sd1331};
      4'd10: d = '{1'b1, 1'b1, -14'sd3437};
      4'd11: d = '{1'b0, 1'b1, -14'sd2178};
      4'd12: d = '{1'b0, 1'b1, -14'sd431};
      4'd13: d = '{1'b0, 1'b1, 14'sd1175};
      4'd14: d = '{1'b0, 1'b1, 14'sd3200};
      default: d = '{1'b1, 1'b0, -14'sd2365};
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/grid_ray_cast_range.sv
// ----------------------------------------------------------------------------
// grid_ray_cast_range
// Occupancy-grid ray caster with an APB register port.
// ----------------------------------------------------------------------------
// A cast walks the ray cell by cell: the walk engine alternates a step and a
// read on its single grid read port, then takes a bit-pair square root of
// the distance. A two-entry queue lets commands be given while a walk runs;
// busy is high only when it is full. Results appear for one cycle with done
// high.
// ----------------------------------------------------------------------------
module grid_ray_cast_range (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [6:0]  cell_x,
  input  logic [6:0]  cell_y,
  input  logic [1:0]  cell_code,
  input  logic [3:0]  direction,
  output logic        done,
  output logic [11:0] range_q4,
  output logic        start_unknown,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] map_rows;
  logic [7:0] map_cols;
  logic       cmd_valid;
  logic       cmd_take;
  grc_pkg::grc_cmd_t cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows <= 8'd128;
      map_cols <= 8'd128;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == grc_pkg::RegMapRows) map_rows <= pwdata[7:0];
      else                                 map_cols <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == grc_pkg::RegMapRows) prdata = {24'd0, map_rows};
    else                                 prdata = {24'd0, map_cols};
  end

  grc_front u_front (
    .clk, .rst, .start, .busy, .op, .cell_x, .cell_y, .cell_code, .direction,
    .cmd_valid, .cmd, .cmd_take
  );

  grc_back u_back (
    .clk, .rst, .map_rows, .map_cols, .cmd_valid, .cmd, .cmd_take,
    .done, .range_q4, .start_unknown
  );

endmodule

FILE: hw/rtl/grc_front.sv
// ----------------------------------------------------------------------------
// grc_front
// Accepts commands and holds them in a short queue for the walk engine.
// ----------------------------------------------------------------------------
module grc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op,
  input  logic [6:0]            cell_x,
  input  logic [6:0]            cell_y,
  input  logic [1:0]            cell_code,
  input  logic [3:0]            direction,
  output logic                  cmd_valid,
  output grc_pkg::grc_cmd_t     cmd,
  input  logic                  cmd_take
);

  grc_pkg::grc_cmd_t queue [grc_pkg::QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign busy      = (count == 2'(grc_pkg::QueueDepth));
  assign push      = start && !busy;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op == grc_pkg::OpCast, cell_x, cell_y, cell_code, direction};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hw/rtl/grc_back.sv
// ----------------------------------------------------------------------------
// grc_back
// Grid store, ray walk and integer square root for the distance.
// ----------------------------------------------------------------------------
module grc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        map_rows,
  input  logic [7:0]        map_cols,
  input  logic              cmd_valid,
  input  grc_pkg::grc_cmd_t cmd,
  output logic              cmd_take,
  output logic              done,
  output logic [11:0]       range_q4,
  output logic              start_unknown
);

  logic [1:0] grid [grc_pkg::GridSide * grc_pkg::GridSide];
  logic [1:0] rd_data;
  logic [13:0] rd_addr;

  grc_pkg::grc_state_t state, state_next;
  grc_pkg::grc_cmd_t   job;
  grc_pkg::grc_dir_t   dinfo;
  logic [7:0]  rows, cols;
  logic [7:0]  steps;
  logic signed [9:0] px, py;
  logic signed [9:0] nx, ny;
  logic signed [22:0] acc;
  logic signed [22:0] acc_next;
  logic signed [9:0] nmin;
  logic signed [9:0] mmaj;
  logic        in_map;
  logic [22:0] rem;
  logic [11:0] root;
  logic [3:0]  iter;
  logic [22:0] sq;
  logic signed [8:0] dx, dy;
  logic [13:0] trial;

  assign rows = (map_rows > 8'd128) ? 8'd128 : map_rows;
  assign cols = (map_cols > 8'd128) ? 8'd128 : map_cols;
  assign dinfo = grc_pkg::dir_info(job.direction);

  // Minor coordinate: start minor times 4096 plus accumulated slope, truncated to zero.
  assign acc_next = acc + 23'(dinfo.slope);
  assign nmin = acc_next[22] ? -10'(((-acc_next) >>> 12)) : 10'(acc_next >>> 12);
  assign mmaj = (dinfo.xmajor ? px : py) + (dinfo.step_neg ? -10'sd1 : 10'sd1);
  assign nx = dinfo.xmajor ? mmaj : nmin;
  assign ny = dinfo.xmajor ? nmin : mmaj;
  assign in_map = !nx[9] && !ny[9] && (nx < $signed({2'b0, rows})) &&
                  (ny < $signed({2'b0, cols}));

  // During the walk the proposed cell is read, so its code is ready in the odd phase.
  always_comb begin
    rd_addr = {job.x, job.y};
    if (state == grc_pkg::ST_WALK) rd_addr = {nx[6:0], ny[6:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd_valid && !cmd.is_cast) begin
      grid[{cmd.x, cmd.y}] <= cmd.code;
    end
    rd_data <= grid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= grc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    case (state)
      grc_pkg::ST_IDLE: begin
        cmd_take = 1'b1;
        if (cmd_valid && cmd.is_cast) state_next = grc_pkg::ST_START;
      end
      grc_pkg::ST_START:  state_next = grc_pkg::ST_CHECK;
      grc_pkg::ST_CHECK: begin
        if ({1'b0, job.x} >= rows || {1'b0, job.y} >= cols ||
            rd_data == grc_pkg::CellUnknown) state_next = grc_pkg::ST_DONE;
        else state_next = grc_pkg::ST_WALK;
      end
      grc_pkg::ST_WALK:   state_next = grc_pkg::ST_WALK;
      grc_pkg::ST_SQUARE: state_next = grc_pkg::ST_ROOT;
      grc_pkg::ST_ROOT:   if (iter == 4'd0) state_next = grc_pkg::ST_DONE;
      grc_pkg::ST_DONE:   state_next = grc_pkg::ST_IDLE;
      default:            state_next = grc_pkg::ST_IDLE;
    endcase
    // The walk alternates: a step proposal is tested, then the grid is read.
    if (state == grc_pkg::ST_WALK && steps[0] == 1'b0 && !in_map)
      state_next = grc_pkg::ST_SQUARE;
    if (state == grc_pkg::ST_WALK && steps[0] == 1'b1 &&
        (rd_data == grc_pkg::CellOccupied || rd_data == grc_pkg::CellUnknown))
      state_next = grc_pkg::ST_SQUARE;
  end

  assign dx = 9'(px) - 9'($signed({1'b0, job.x}));
  assign dy = 9'(py) - 9'($signed({1'b0, job.y}));
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == grc_pkg::ST_DONE);
    case (state)
      grc_pkg::ST_IDLE: begin
        if (cmd_valid && cmd.is_cast) job <= cmd;
      end
      grc_pkg::ST_START: begin
        px    <= 10'($signed({1'b0, job.x}));
        py    <= 10'($signed({1'b0, job.y}));
        acc   <= 23'($signed({1'b0, (dinfo.xmajor ? job.y : job.x), 12'd0}));
        steps <= 8'd0;
      end
      grc_pkg::ST_CHECK: begin
        start_unknown <= (state_next != grc_pkg::ST_WALK);
        range_q4      <= 12'd0;
      end
      grc_pkg::ST_WALK: begin
        // Even phase: advance; odd phase: grid data for new cell is present.
        if (steps[0] == 1'b0) begin
          px  <= nx;
          py  <= ny;
          acc <= acc_next;
        end
        steps <= steps + 8'd1;
      end
      grc_pkg::ST_SQUARE: begin
        // The root loop reads sq with a zero bit appended, so loading the
        // squared distance shifted by seven gives a radicand of 256 times it.
        sq   <= (23'(dx) * 23'(dx) + 23'(dy) * 23'(dy)) << 7;
        rem  <= '0;
        root <= '0;
        iter <= 4'd11;
      end
      grc_pkg::ST_ROOT: begin
        // Twelve digit pairs are taken from the top of sq.
        if ({rem[20:0], sq[22:21]} >= 23'(trial)) begin
          rem  <= {rem[20:0], sq[22:21]} - 23'(trial);
          root <= {root[10:0], 1'b1};
        end else begin
          rem  <= {rem[20:0], sq[22:21]};
          root <= {root[10:0], 1'b0};
        end
        sq   <= {sq[20:0], 2'b00};
        iter <= iter - 4'd1;
      end
      grc_pkg::ST_DONE: begin
        if (start_unknown == 1'b0) begin
          if (root == 12'hFFF || rem > 23'(root)) range_q4 <= (root == 12'hFFF) ? root : root + 12'd1;
          else range_q4 <= root;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for grid_ray_cast_range
// Loads a walled corner of the grid, then runs directed and random cell
// writes and ray casts under several map sizes. A scoreboard predicts each
// cast's range and compares it with the block's results in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Casts that walk start inside a loaded square whose far row and column are occupied,
  // so a ray never reaches a cell that was not loaded.
  localparam int WallAt = 15;

  typedef struct {
    logic [11:0] range_q4;
    logic        start_unknown;
  } cast_result_t;

  class range_scoreboard;
    logic [1:0]   grid [grc_pkg::GridSide*grc_pkg::GridSide];
    int           rows = 128;
    int           cols = 128;
    cast_result_t pending [$];
    int           errors = 0;
    int           tan_q12 [46] = '{
      0, 71, 143, 215, 286, 358, 431, 503, 576, 649,
      722, 796, 871, 946, 1021, 1098, 1175, 1252, 1331, 1410,
      1491, 1572, 1655, 1739, 1824, 1910, 1998, 2087, 2178, 2270,
      2365, 2461, 2559, 2660, 2763, 2868, 2976, 3087, 3200, 3317,
      3437, 3561, 3688, 3820, 3955, 4096};

    function void set_reg(logic [0:0] idx, logic [7:0] value);
      if (idx == grc_pkg::RegMapRows) rows = value;
      else cols = value;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_item(logic opv, logic [6:0] x0, logic [6:0] y0,
                            logic [1:0] code, logic [3:0] dir);
      cast_result_t res;
      int rws, cls, deg, sector, stepdir, tidx;
      bit xmajor, neg;
      longint slope, m0, n0, m, n, v, x, y, dx, dy;
      longint unsigned sq, r;
      rws = rows < grc_pkg::GridSide ? rows : grc_pkg::GridSide;
      cls = cols < grc_pkg::GridSide ? cols : grc_pkg::GridSide;
      if (opv == grc_pkg::OpWrite) begin
        grid[x0 * grc_pkg::GridSide + y0] = code;
        return;
      end
      if (x0 >= rws || y0 >= cls ||
          grid[x0 * grc_pkg::GridSide + y0] == grc_pkg::CellUnknown) begin
        res.range_q4 = 0;
        res.start_unknown = 1'b1;
        pending.push_back(res);
        return;
      end
      deg = 22 * dir;
      sector = deg / 45;
      xmajor = (sector == 0 || sector == 3 || sector == 4 || sector == 7);
      stepdir = (sector <= 2 || sector == 7) ? 1 : -1;
      case (sector)
        0: begin tidx = deg;       neg = 0; end
        1: begin tidx = 90 - deg;  neg = 0; end
        2: begin tidx = deg - 90;  neg = 1; end
        3: begin tidx = 180 - deg; neg = 1; end
        4: begin tidx = deg - 180; neg = 0; end
        5: begin tidx = 270 - deg; neg = 0; end
        6: begin tidx = deg - 270; neg = 1; end
        default: begin tidx = 360 - deg; neg = 1; end
      endcase
      slope = neg ? -tan_q12[tidx] : tan_q12[tidx];
      m0 = xmajor ? x0 : y0;
      n0 = xmajor ? y0 : x0;
      m = m0;
      forever begin
        m += stepdir;
        v = n0 * 4096 + slope * (m - m0);
        // The minor coordinate truncates toward zero, not toward minus infinity.
        n = (v >= 0) ? (v >>> 12) : -((-v) >>> 12);
        x = xmajor ? m : n;
        y = xmajor ? n : m;
        if (x < 0 || x >= rws || y < 0 || y >= cls) break;
        if (grid[x * grc_pkg::GridSide + y] == grc_pkg::CellOccupied ||
            grid[x * grc_pkg::GridSide + y] == grc_pkg::CellUnknown) break;
      end
      dx = x - x0;
      dy = y - y0;
      sq = (dx * dx + dy * dy) * 256;
      r = int_sqrt(sq);
      if (sq - r * r > r) r++;
      if (r > 4095) r = 4095;
      res.range_q4 = r[11:0];
      res.start_unknown = 1'b0;
      pending.push_back(res);
    endfunction

    function void check_result(logic [11:0] rng, logic unk);
      cast_result_t want;
      if (pending.size() == 0) begin
        $error("result with no cast pending: range_q4 %0d start_unknown %0d", rng, unk);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (rng !== want.range_q4) begin
        $error("range_q4: expected %0d, actual %0d", want.range_q4, rng);
        errors++;
      end
      if (unk !== want.start_unknown) begin
        $error("start_unknown: expected %0d, actual %0d", want.start_unknown, unk);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic        op = grc_pkg::OpWrite;
  logic [6:0]  cell_x = 0;
  logic [6:0]  cell_y = 0;
  logic [1:0]  cell_code = grc_pkg::CellFree;
  logic [3:0]  direction = 0;
  logic        done;
  logic [11:0] range_q4;
  logic        start_unknown;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  range_scoreboard sb = new();
  int burst_mode = 0;

  grid_ray_cast_range i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(range_q4, start_unknown);
  end

  task automatic write_reg(logic [0:0] idx, logic [7:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, value);
  endtask

  function automatic int pick_gap();
    int p;
    if (burst_mode != 0) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // One transfer; start stays high on return so back-to-back items need no gap.
  task automatic send_item(logic opv, logic [6:0] x, logic [6:0] y,
                           logic [1:0] code, logic [3:0] dir, int gap);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1; op <= opv; cell_x <= x; cell_y <= y;
    cell_code <= code; direction <= dir;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(opv, x, y, code, dir);
  endtask

  task automatic wait_idle();
    if (start) begin
      start <= 0;
    end
    while (sb.pending.size() != 0) @(posedge clk);
    // Writes leave no result, so give any queued write time to land.
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [1:0] random_code();
    int p;
    p = $urandom_range(99);
    if (p < 80) return grc_pkg::CellFree;
    if (p < 92) return grc_pkg::CellOccupied;
    if (p < 96) return grc_pkg::CellUnknown;
    return 2'd3;
  endfunction

  initial begin
    logic [7:0] rows_set [8];
    logic [7:0] cols_set [8];
    logic [6:0] rx, ry;
    logic [1:0] code;
    int         rw, cw;
    rows_set = '{128, 1, 0, 255, 64, 128, 200, 37};
    cols_set = '{128, 1, 9, 128, 255, 17, 3, 128};
    repeat (3) @(posedge clk);
    rst <= 0;
    write_reg(grc_pkg::RegMapRows, 8'd128);
    write_reg(grc_pkg::RegMapCols, 8'd128);
    // Load the walled square; its far row and column are occupied.
    for (int i = 0; i < (WallAt + 1) * (WallAt + 1); i++) begin
      rx = 7'(i / (WallAt + 1));
      ry = 7'(i % (WallAt + 1));
      code = (rx == 7'(WallAt) || ry == 7'(WallAt)) ? grc_pkg::CellOccupied
                                                    : random_code();
      send_item(grc_pkg::OpWrite, rx, ry, code, 4'd0, 0);
    end
    // Directed part.
    send_item(grc_pkg::OpWrite, 7'd7, 7'd7, grc_pkg::CellOccupied, 4'd0, 0);
    send_item(grc_pkg::OpWrite, 7'd8, 7'd7, 2'd3, 4'd0, 1);
    for (int k = 0; k < 16; k++)
      send_item(grc_pkg::OpCast, 7'd7, 7'd7, 2'd0, 4'(k), k % 3);
    send_item(grc_pkg::OpWrite, 7'd0, 7'd0, grc_pkg::CellFree, 4'd0, 0);
    send_item(grc_pkg::OpCast, 7'd0, 7'd0, 2'd0, 4'd2, 0);
    send_item(grc_pkg::OpWrite, 7'd14, 7'd14, grc_pkg::CellFree, 4'd0, 0);
    send_item(grc_pkg::OpCast, 7'd14, 7'd14, 2'd0, 4'd8, 2);
    send_item(grc_pkg::OpWrite, 7'd10, 7'd10, grc_pkg::CellUnknown, 4'd0, 0);
    send_item(grc_pkg::OpCast, 7'd10, 7'd10, 2'd0, 4'd15, 0);
    wait_idle();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(grc_pkg::RegMapRows, rows_set[ph]);
      write_reg(grc_pkg::RegMapCols, cols_set[ph]);
      rw = (rows_set[ph] < 8'd128) ? int'(rows_set[ph]) : 128;
      cw = (cols_set[ph] < 8'd128) ? int'(cols_set[ph]) : 128;
      for (int i = 0; i < 60; i++) begin
        if (i % 20 == 0) burst_mode = ($urandom_range(2) == 0);
        rx = 7'($urandom_range(WallAt - 1));
        ry = 7'($urandom_range(WallAt - 1));
        if ($urandom_range(99) < 40) begin
          // Cells beyond the wall are never read, so any code may go there.
          if ($urandom_range(7) == 0) rx = 7'($urandom_range(127, WallAt + 1));
          send_item(grc_pkg::OpWrite, rx, ry, 2'($urandom_range(3)),
                    4'($urandom_range(15)), pick_gap());
        end else begin
          // A start outside the map is never read either.
          if (rw < 128 && $urandom_range(4) == 0) rx = 7'($urandom_range(127, rw));
          if (cw < 128 && $urandom_range(4) == 0) ry = 7'($urandom_range(127, cw));
          send_item(grc_pkg::OpCast, rx, ry, 2'($urandom_range(3)),
                    4'($urandom_range(15)), pick_gap());
        end
      end
      wait_idle();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** grid_ray_cast_range: PASSED **");
    end else begin
      $display("** grid_ray_cast_range: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** grid_ray_cast_range: FAILED **");
    $finish;
  end

endmodule
